FILE: design/kvt_pkg.sv
// Package for the bounded key/value table: sizes, command codes and the
// packed payload types of the input and result channels.
// No dependencies.
package kvt_pkg;

  localparam int ENTRIES    = 64;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int CNT_W      = $clog2(ENTRIES + 1);
  localparam int CMD_W      = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT   = 3'd0,
    CMD_UPDATE   = 3'd1,
    CMD_UPSERT   = 3'd2,
    CMD_ERASE    = 3'd3,
    CMD_LOOKUP   = 3'd4,
    CMD_READ_POS = 3'd5
  } cmd_t;

  typedef struct packed {
    cmd_t                  cmd;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic [IDX_W-1:0]      position;
  } in_item_t;

  typedef struct packed {
    logic                  ok;
    logic [KEY_BITS-1:0]   key_out;
    logic [VALUE_BITS-1:0] value_out;
    logic [CNT_W-1:0]      count;
    logic                  is_empty;
  } out_item_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } entry_t;

endpackage

FILE: design/bounded_key_value_table.sv
// Bounded key/value table, top level: pair memory, search and shift sequencer.
// Depends on kvt_pkg.
//
// The table holds up to kvt_pkg::ENTRIES key/value pairs in insertion order
// in a single-port-write, single-port-read memory with a registered read.
// One command is worked on at a time and in_ready is high only while the
// sequencer is idle. Insert, update, upsert, erase and lookup then scan the
// stored pairs with one comparator, one pair per cycle, until a hit or the
// end of the table; the execute state then applies the command. Erase of a
// present key then moves every later pair down one place, one pair per cycle
// through the same read and write ports. Read by position within the count
// reads the pair in the position-read state; beyond it, and for unused
// command codes, the sequencer goes straight to the hand-over state. The
// result is then handed over; the longest command is an erase in a full
// table. The result sits in an output register, so a new command may be
// accepted while it waits, but that command cannot hand over its own result
// until the register has been freed.
module bounded_key_value_table (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  kvt_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output kvt_pkg::out_item_t out_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_EXEC,
    S_SHIFT,
    S_POS_RD,
    S_DONE
  } state_t;

  state_t                          state_r;
  kvt_pkg::in_item_t               req_r;
  logic [kvt_pkg::CNT_W-1:0]       cnt_r;
  logic [kvt_pkg::CNT_W-1:0]       scan_r;
  logic                            pend_r;
  logic [kvt_pkg::IDX_W-1:0]       pend_idx_r;
  logic                            hit_r;
  logic [kvt_pkg::IDX_W-1:0]       hit_idx_r;
  logic [kvt_pkg::VALUE_BITS-1:0]  hit_val_r;
  logic                            res_ok_r;
  logic [kvt_pkg::KEY_BITS-1:0]    res_key_r;
  logic [kvt_pkg::VALUE_BITS-1:0]  res_val_r;
  logic                            out_valid_r;
  kvt_pkg::out_item_t              out_data_r;

  kvt_pkg::entry_t                 mem [kvt_pkg::ENTRIES];
  kvt_pkg::entry_t                 rd_data_r;

  logic                            mem_we;
  logic [kvt_pkg::IDX_W-1:0]       mem_wa;
  kvt_pkg::entry_t                 mem_wd;
  logic                            mem_re;
  logic [kvt_pkg::IDX_W-1:0]       mem_ra;

  logic                            scan_issue;
  logic                            key_match;
  logic                            pos_ok;
  logic                            out_free;

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_free   = !out_valid_r || out_ready;

  // During a search the scan pointer runs over [0, count); during a shift
  // it runs over the sources [hit + 1, count], count already decremented.
  assign scan_issue = (state_r == S_SHIFT) ? (scan_r <= cnt_r) : (scan_r < cnt_r);
  assign key_match  = pend_r && (rd_data_r.key == req_r.key);
  assign pos_ok     = {1'b0, in_data.position} < cnt_r;

  // Memory port control.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    mem_re = 1'b0;
    mem_ra = scan_r[kvt_pkg::IDX_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        mem_re = in_valid && (in_data.cmd == kvt_pkg::CMD_READ_POS) && pos_ok;
        mem_ra = in_data.position;
      end
      S_SEARCH: begin
        mem_re = scan_issue;
      end
      S_EXEC: begin
        mem_wd.key   = req_r.key;
        mem_wd.value = req_r.value;
        if (req_r.cmd == kvt_pkg::CMD_INSERT || req_r.cmd == kvt_pkg::CMD_UPDATE ||
            req_r.cmd == kvt_pkg::CMD_UPSERT) begin
          if (hit_r && req_r.cmd != kvt_pkg::CMD_INSERT) begin
            mem_we = 1'b1;
            mem_wa = hit_idx_r;
          end else if (!hit_r && req_r.cmd != kvt_pkg::CMD_UPDATE &&
                       cnt_r < kvt_pkg::CNT_W'(kvt_pkg::ENTRIES)) begin
            mem_we = 1'b1;
            mem_wa = cnt_r[kvt_pkg::IDX_W-1:0];
          end
        end
      end
      S_SHIFT: begin
        mem_re = scan_issue;
        mem_we = pend_r;
        mem_wa = pend_idx_r - kvt_pkg::IDX_W'(1);
        mem_wd = rd_data_r;
      end
      S_POS_RD, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  // Sequencer with its registered results.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      scan_r      <= '0;
      pend_r      <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // In the hand-over state the output register is reloaded further down.
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r     <= in_data;
            res_ok_r  <= 1'b0;
            res_key_r <= '0;
            res_val_r <= '0;
            scan_r    <= '0;
            pend_r    <= 1'b0;
            hit_r     <= 1'b0;
            if (in_data.cmd == kvt_pkg::CMD_INSERT || in_data.cmd == kvt_pkg::CMD_UPDATE ||
                in_data.cmd == kvt_pkg::CMD_UPSERT || in_data.cmd == kvt_pkg::CMD_ERASE ||
                in_data.cmd == kvt_pkg::CMD_LOOKUP) begin
              state_r <= S_SEARCH;
            end else if (in_data.cmd == kvt_pkg::CMD_READ_POS && pos_ok) begin
              state_r <= S_POS_RD;
            end else begin
              state_r <= S_DONE;
            end
          end
        end

        S_SEARCH: begin
          if (scan_issue) begin
            scan_r <= scan_r + kvt_pkg::CNT_W'(1);
          end
          pend_r     <= scan_issue;
          pend_idx_r <= scan_r[kvt_pkg::IDX_W-1:0];
          if (key_match) begin
            hit_r     <= 1'b1;
            hit_idx_r <= pend_idx_r;
            hit_val_r <= rd_data_r.value;
            state_r   <= S_EXEC;
          end else if (!pend_r && !scan_issue) begin
            hit_r   <= 1'b0;
            state_r <= S_EXEC;
          end
        end

        S_EXEC: begin
          state_r <= (req_r.cmd == kvt_pkg::CMD_ERASE && hit_r) ? S_SHIFT : S_DONE;
          unique case (req_r.cmd)
            kvt_pkg::CMD_INSERT, kvt_pkg::CMD_UPDATE, kvt_pkg::CMD_UPSERT: begin
              if (hit_r && req_r.cmd != kvt_pkg::CMD_INSERT) begin
                res_ok_r <= 1'b1;
              end else if (!hit_r && req_r.cmd != kvt_pkg::CMD_UPDATE &&
                           cnt_r < kvt_pkg::CNT_W'(kvt_pkg::ENTRIES)) begin
                res_ok_r <= 1'b1;
                cnt_r    <= cnt_r + kvt_pkg::CNT_W'(1);
              end
            end
            kvt_pkg::CMD_ERASE: begin
              if (hit_r) begin
                res_ok_r <= 1'b1;
                cnt_r    <= cnt_r - kvt_pkg::CNT_W'(1);
                scan_r   <= kvt_pkg::CNT_W'(hit_idx_r) + kvt_pkg::CNT_W'(1);
                pend_r   <= 1'b0;
              end
            end
            kvt_pkg::CMD_LOOKUP: begin
              if (hit_r) begin
                res_ok_r  <= 1'b1;
                res_val_r <= hit_val_r;
              end
            end
            default: begin
            end
          endcase
        end

        S_SHIFT: begin
          // Each pair read here is written one place lower in the next cycle.
          if (scan_issue) begin
            scan_r <= scan_r + kvt_pkg::CNT_W'(1);
          end
          pend_r     <= scan_issue;
          pend_idx_r <= scan_r[kvt_pkg::IDX_W-1:0];
          if (!pend_r && !scan_issue) begin
            state_r <= S_DONE;
          end
        end

        S_POS_RD: begin
          res_ok_r  <= 1'b1;
          res_key_r <= rd_data_r.key;
          res_val_r <= rd_data_r.value;
          state_r   <= S_DONE;
        end

        S_DONE: begin
          if (out_free) begin
            out_valid_r          <= 1'b1;
            out_data_r.ok        <= res_ok_r;
            out_data_r.key_out   <= res_key_r;
            out_data_r.value_out <= res_val_r;
            out_data_r.count     <= cnt_r;
            out_data_r.is_empty  <= (cnt_r == '0);
            state_r              <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sim/tb_bounded_key_value_table.sv
// Self-checking testbench for the bounded key/value table: a clocked driver and
// monitor around the block, with a behavioural copy of the table predicting results.
// Depends on kvt_pkg and bounded_key_value_table.
`timescale 1ns / 100ps

module tb_bounded_key_value_table;
  import kvt_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  localparam int POOL_SIZE        = 80;
  localparam int ITEM_TARGET      = 1000;
  localparam int TAIL_ITEMS       = 100;
  localparam int LONG_HOLD_AT     = 200;
  localparam int LONG_HOLD_CYCLES = 500;
  localparam int DRAIN_CYCLES     = 20;
  localparam int CYCLE_LIMIT      = 1000000;

  localparam int MODE_GROW   = 0;
  localparam int MODE_SHRINK = 1;
  localparam int MODE_MIXED  = 2;

  typedef struct {
    bit       hold;  // not a command: wait until every result is back
    in_item_t item;
  } backlog_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  backlog_t  cmd_backlog[$];
  out_item_t predicted_replies[$];
  logic [KEY_BITS-1:0] key_pool[POOL_SIZE];

  // Behavioural copy of the table.
  logic [KEY_BITS-1:0]   shadow_keys[ENTRIES];
  logic [VALUE_BITS-1:0] shadow_vals[ENTRIES];
  int stored = 0;

  int  n_items = 0;
  int  n_predicted = 0;
  int  n_checked = 0;
  int  n_full_refusals = 0;
  int  n_emptied = 0;
  int  errors = 0;
  int  idle_left = 0;
  int  hold_left = 0;
  int  cycle_count = 0;
  bit  tail_phase = 1'b0;
  bit  long_hold_done = 1'b0;

  bounded_key_value_table dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Works out the reply to one command and updates the shadow table.
  function automatic out_item_t apply_command(input in_item_t c);
    out_item_t r;
    int hit;
    int i;
    r = '0;
    hit = -1;
    for (i = 0; i < stored; i++) begin
      if (hit < 0 && shadow_keys[i] == c.key) hit = i;
    end
    case (c.cmd)
      CMD_INSERT, CMD_UPDATE, CMD_UPSERT: begin
        if (hit >= 0 && c.cmd != CMD_INSERT) begin
          shadow_vals[hit] = c.value;
          r.ok = 1'b1;
        end else if (hit < 0 && c.cmd != CMD_UPDATE && stored < ENTRIES) begin
          shadow_keys[stored] = c.key;
          shadow_vals[stored] = c.value;
          stored++;
          r.ok = 1'b1;
        end else if (hit < 0 && c.cmd != CMD_UPDATE) begin
          n_full_refusals++;
        end
      end
      CMD_ERASE: begin
        if (hit >= 0) begin
          stored--;
          // Later pairs move down one place so that insertion order is kept.
          for (i = hit; i < stored; i++) begin
            shadow_keys[i] = shadow_keys[i + 1];
            shadow_vals[i] = shadow_vals[i + 1];
          end
          r.ok = 1'b1;
          if (stored == 0) n_emptied++;
        end
      end
      CMD_LOOKUP: begin
        if (hit >= 0) begin
          r.value_out = shadow_vals[hit];
          r.ok = 1'b1;
        end
      end
      CMD_READ_POS: begin
        if (int'(c.position) < stored) begin
          r.key_out   = shadow_keys[c.position];
          r.value_out = shadow_vals[c.position];
          r.ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.count    = CNT_W'(stored);
    r.is_empty = (stored == 0);
    return r;
  endfunction

  task automatic queue_cmd(input logic [CMD_W-1:0] code, input logic [KEY_BITS-1:0] k,
                           input logic [VALUE_BITS-1:0] v, input logic [IDX_W-1:0] pos);
    backlog_t b;
    b.hold          = 1'b0;
    b.item.cmd      = cmd_t'(code);
    b.item.key      = k;
    b.item.value    = v;
    b.item.position = pos;
    cmd_backlog.push_back(b);
    n_items++;
  endtask

  task automatic queue_pause();
    backlog_t b;
    b.hold = 1'b1;
    b.item = '0;
    cmd_backlog.push_back(b);
  endtask

  // One random command; the mode sets the mix and span how many pool keys are in play.
  task automatic queue_random(input int mode, input int span);
    logic [CMD_W-1:0] codes[8];
    int weights[8];
    int r;
    int acc;
    int sel;
    int j;
    logic [KEY_BITS-1:0] k;
    codes = '{CMD_INSERT, CMD_UPDATE, CMD_UPSERT, CMD_ERASE,
              CMD_LOOKUP, CMD_READ_POS, CMD_SPARE_6, CMD_SPARE_7};
    case (mode)
      MODE_GROW:   weights = '{40, 5, 25, 5, 10, 13, 1, 1};
      MODE_SHRINK: weights = '{5, 10, 5, 50, 12, 16, 1, 1};
      default:     weights = '{18, 12, 15, 18, 17, 18, 1, 1};
    endcase
    r = $urandom_range(0, 99);
    acc = 0;
    sel = 0;
    for (j = 7; j >= 0; j--) begin
      acc += weights[7 - j];
      if (r < acc && sel == 0) sel = 8 - j;
    end
    if (sel == 0) sel = 8;
    k = key_pool[$urandom_range(0, span - 1)];
    // Keys outside the pool are only ever missed, never stored.
    if (codes[sel - 1] != CMD_INSERT && codes[sel - 1] != CMD_UPSERT &&
        $urandom_range(0, 99) < 15)
      k = $urandom();
    queue_cmd(codes[sel - 1], k, $urandom(), IDX_W'($urandom_range(0, 63)));
  endtask

  initial begin : stimulus_proc
    int i;
    int n;
    int round;
    int span;
    bit upward;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (i = 2; i < POOL_SIZE; i++) key_pool[i] = ($urandom() & 32'hFFFF_FF00) | 32'(i);

    // Directed part: empty table, extreme keys and values, refusals and misses.
    queue_cmd(CMD_LOOKUP, '0, '0, '0);
    queue_cmd(CMD_READ_POS, '0, '0, '0);
    queue_cmd(CMD_ERASE, '1, '0, '0);
    queue_cmd(CMD_UPDATE, '0, '1, '0);
    queue_cmd(CMD_INSERT, '0, '0, '0);
    queue_cmd(CMD_INSERT, '1, '1, '1);
    queue_cmd(CMD_INSERT, '0, 32'h1234_5678, '0);
    queue_cmd(CMD_UPSERT, '0, 32'hA5A5_5A5A, '0);
    queue_cmd(CMD_UPSERT, 32'h8000_0001, 32'h0000_0001, '0);
    queue_cmd(CMD_UPDATE, '1, '0, '0);
    queue_cmd(CMD_LOOKUP, '1, '1, '0);
    queue_cmd(CMD_LOOKUP, 32'h8000_0000, '0, '0);
    queue_cmd(CMD_READ_POS, '0, '0, 6'd0);
    queue_cmd(CMD_READ_POS, '0, '0, 6'd2);
    queue_cmd(CMD_READ_POS, '0, '0, 6'd3);
    queue_cmd(CMD_READ_POS, '1, '1, '1);
    queue_cmd(CMD_ERASE, '0, '0, '0);
    queue_cmd(CMD_READ_POS, '0, '0, 6'd0);
    queue_cmd(CMD_SPARE_6, '1, '1, '1);
    queue_cmd(CMD_SPARE_7, '0, '0, '0);
    queue_cmd(CMD_ERASE, '1, '0, '0);
    queue_cmd(CMD_ERASE, 32'h8000_0001, '0, '0);
    queue_cmd(CMD_LOOKUP, '0, '0, '0);
    queue_pause();

    // Fill to capacity, then probe the full table.
    for (i = 0; i < ENTRIES; i++)
      queue_cmd(CMD_INSERT, key_pool[i], $urandom(), IDX_W'($urandom()));
    queue_cmd(CMD_INSERT, key_pool[64], $urandom(), '0);
    queue_cmd(CMD_UPSERT, key_pool[65], $urandom(), '0);
    queue_cmd(CMD_UPSERT, key_pool[3], $urandom(), '0);
    queue_cmd(CMD_INSERT, key_pool[7], $urandom(), '0);
    queue_cmd(CMD_READ_POS, '0, '0, 6'd63);
    queue_cmd(CMD_LOOKUP, key_pool[63], '0, '0);
    queue_cmd(CMD_ERASE, key_pool[0], '0, '0);
    queue_cmd(CMD_READ_POS, '0, '0, 6'd62);
    queue_cmd(CMD_READ_POS, '0, '0, 6'd63);
    queue_pause();

    round = 0;
    while (n_items < ITEM_TARGET) begin
      round++;
      if (round % 4 == 0) queue_pause();
      if (round % 6 == 0) begin
        // Erase every pool key so that the table is certain to end up empty.
        upward = 1'($urandom_range(0, 1));
        for (i = 0; i < POOL_SIZE; i++)
          queue_cmd(CMD_ERASE, key_pool[upward ? i : POOL_SIZE - 1 - i], $urandom(),
                    IDX_W'($urandom()));
      end else begin
        case ($urandom_range(0, 2))
          0:       span = 6;
          1:       span = 24;
          default: span = POOL_SIZE;
        endcase
        n = $urandom_range(15, 60);
        for (i = 0; i < n; i++) queue_random($urandom_range(MODE_GROW, MODE_MIXED), span);
      end
    end

    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (!(cmd_backlog.size() == 0 && !in_valid && n_predicted == n_checked));
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Summary: %0d commands sent, %0d replies checked, %0d mismatches.",
             n_predicted, n_checked, errors);
    $display("Summary: %0d refusals on a full table, table emptied by erase %0d times.",
             n_full_refusals, n_emptied);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog_proc
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d replies outstanding.", cycle_count,
             predicted_replies.size());
    $display("Verification failed");
    $finish;
  end

  // Command driver.
  always @(posedge clk) begin : driver_proc
    logic     taken;
    logic     nxt_valid;
    in_item_t nxt_data;
    backlog_t b;
    if (!rst_n) begin
      in_valid    <= 1'b0;
      in_data     <= '0;
      idle_left   <= 0;
      n_predicted <= 0;
    end else begin
      taken     = in_valid && in_ready;
      nxt_valid = in_valid && !taken;
      nxt_data  = in_data;
      if (taken) begin
        predicted_replies.push_back(apply_command(in_data));
        n_predicted <= n_predicted + 1;
      end
      if (!nxt_valid) begin
        if (idle_left > 0) begin
          idle_left <= idle_left - 1;
        end else if (cmd_backlog.size() != 0) begin
          if (cmd_backlog[0].hold) begin
            if (!taken && n_predicted == n_checked) b = cmd_backlog.pop_front();
          end else if (!tail_phase && $urandom_range(0, 11) == 0) begin
            idle_left <= $urandom_range(1, 11) - 1;
          end else begin
            b = cmd_backlog.pop_front();
            nxt_valid = 1'b1;
            nxt_data  = b.item;
          end
        end
      end
      in_valid   <= nxt_valid;
      in_data    <= nxt_data;
      tail_phase <= (n_predicted >= n_items - TAIL_ITEMS);
    end
  end

  // Result-side back-pressure, including one long hold that fills the block up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready      <= 1'b0;
      hold_left      <= 0;
      long_hold_done <= 1'b0;
    end else if (!long_hold_done && n_predicted >= LONG_HOLD_AT) begin
      long_hold_done <= 1'b1;
      hold_left      <= LONG_HOLD_CYCLES - 1;
      out_ready      <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!tail_phase && $urandom_range(0, 9) == 0) begin
      hold_left <= $urandom_range(1, 11) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      errors++;
    end
  endtask

  // Reply monitor: each transfer is checked against the oldest prediction.
  always @(posedge clk) begin : monitor_proc
    out_item_t want;
    if (!rst_n) begin
      n_checked <= 0;
    end else if (out_valid && out_ready) begin
      if (predicted_replies.size() == 0) begin
        $display("%0t: unexpected reply, expected none, actual %0h", $time, out_data);
        errors++;
      end else begin
        want = predicted_replies.pop_front();
        check_field("ok", 64'(want.ok), 64'(out_data.ok));
        check_field("key_out", 64'(want.key_out), 64'(out_data.key_out));
        check_field("value_out", 64'(want.value_out), 64'(out_data.value_out));
        check_field("count", 64'(want.count), 64'(out_data.count));
        check_field("is_empty", 64'(want.is_empty), 64'(out_data.is_empty));
      end
      n_checked <= n_checked + 1;
    end
  end

endmodule
